// File: design/pss_pkg.sv
package pss_pkg;

  localparam int DEFAULT_DEPTH      = 16;
  localparam int DEFAULT_WORD_WIDTH = 32;
  localparam int POS_WIDTH          = 5;
  localparam int VALUE_WIDTH        = 32;
  localparam int COUNT_WIDTH        = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_DELETE = 2'd2,
    OP_SWAP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // What a cell loads on this clock.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD_WORD,
    CELL_LOAD_SWAP
  } cell_mode_t;

endpackage

// File: design/pss_cell.sv
module pss_cell #(
  parameter int WORD_WIDTH = pss_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                   clk,
  input  pss_pkg::cell_mode_t    mode,
  input  logic [WORD_WIDTH-1:0]  left_word,
  input  logic [WORD_WIDTH-1:0]  right_word,
  input  logic [WORD_WIDTH-1:0]  new_word,
  input  logic [WORD_WIDTH-1:0]  swap_word,
  output logic [WORD_WIDTH-1:0]  word
);

  always_ff @(posedge clk) begin
    case (mode)
      pss_pkg::CELL_FROM_LEFT:  word <= left_word;
      pss_pkg::CELL_FROM_RIGHT: word <= right_word;
      pss_pkg::CELL_LOAD_WORD:  word <= new_word;
      pss_pkg::CELL_LOAD_SWAP:  word <= swap_word;
      default:                  word <= word;
    endcase
  end

endmodule

// File: design/positional_sequence_store.sv
// Ordered store of up to DEPTH words held in a row of cells, one word per
// cell. Insert and append shift the tail one cell right, delete shifts it one
// cell left, swap exchanges two cells; every transaction returns a status and
// the entry count. One transaction is taken per clock: the whole row moves and
// the result is written into the output register on the clock edge that accepts
// the transaction, so the input stays ready while the output is empty or being
// taken. Rejected operations leave the contents unchanged.
module positional_sequence_store #(
  parameter int DEPTH      = pss_pkg::DEFAULT_DEPTH,
  parameter int WORD_WIDTH = pss_pkg::DEFAULT_WORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          operation,
  input  logic [pss_pkg::POS_WIDTH-1:0]       position,
  input  logic [pss_pkg::POS_WIDTH-1:0]       other_position,
  input  logic signed [pss_pkg::VALUE_WIDTH-1:0] value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic [pss_pkg::COUNT_WIDTH-1:0]     entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int XW = ((CW > pss_pkg::POS_WIDTH) ? CW : pss_pkg::POS_WIDTH) + 1;

  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [WORD_WIDTH-1:0]  words [DEPTH];
  logic [WORD_WIDTH-1:0]  new_word;
  logic [WORD_WIDTH-1:0]  word_a;
  logic [WORD_WIDTH-1:0]  word_b;
  logic [XW-1:0]          pos_x;
  logic [XW-1:0]          oth_x;
  logic [XW-1:0]          cnt_x;
  logic [XW-1:0]          at_x;
  logic                   is_insert;
  logic                   take;
  logic                   ins_ok;
  logic                   del_ok;
  logic                   swp_ok;
  pss_pkg::status_t       status_next;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign pos_x    = XW'(position);
  assign oth_x    = XW'(other_position);
  assign cnt_x    = XW'(count);
  assign new_word = WORD_WIDTH'(value);

  assign is_insert = (operation == pss_pkg::OP_INSERT) || (operation == pss_pkg::OP_APPEND);
  assign at_x      = (operation == pss_pkg::OP_APPEND) ? cnt_x : pos_x;

  assign word_a = words[IW'(pos_x - XW'(1))];
  assign word_b = words[IW'(oth_x - XW'(1))];

  always_comb begin
    status_next = pss_pkg::ST_DONE;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    swp_ok      = 1'b0;
    count_next  = count;
    if (is_insert) begin
      if (at_x > cnt_x) begin
        status_next = pss_pkg::ST_RANGE;
      end else if (cnt_x == XW'(DEPTH)) begin
        status_next = pss_pkg::ST_FULL;
      end else begin
        ins_ok     = 1'b1;
        count_next = count + CW'(1);
      end
    end else if (operation == pss_pkg::OP_DELETE) begin
      if (pos_x == '0 || pos_x > cnt_x) begin
        status_next = pss_pkg::ST_RANGE;
      end else begin
        del_ok     = 1'b1;
        count_next = count - CW'(1);
      end
    end else begin
      if (pos_x == '0 || oth_x <= pos_x || oth_x > cnt_x) begin
        status_next = pss_pkg::ST_RANGE;
      end else begin
        swp_ok = 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [XW-1:0] IDX  = XW'(i);
    localparam logic [XW-1:0] IDX1 = XW'(i + 1);
    pss_pkg::cell_mode_t   mode;
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;
    logic [WORD_WIDTH-1:0] swap_word;

    if (i == 0) begin : g_first
      assign left_word = words[i];
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_word = words[i];
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    assign swap_word = (IDX1 == pos_x) ? word_b : word_a;

    always_comb begin
      mode = pss_pkg::CELL_HOLD;
      if (take) begin
        if (ins_ok) begin
          if (IDX == at_x) begin
            mode = pss_pkg::CELL_LOAD_WORD;
          end else if (IDX > at_x) begin
            mode = pss_pkg::CELL_FROM_LEFT;
          end
        end else if (del_ok) begin
          if (IDX1 >= pos_x) begin
            mode = pss_pkg::CELL_FROM_RIGHT;
          end
        end else if (swp_ok) begin
          if (IDX1 == pos_x || IDX1 == oth_x) begin
            mode = pss_pkg::CELL_LOAD_SWAP;
          end
        end
      end
    end

    pss_cell #(
      .WORD_WIDTH(WORD_WIDTH)
    ) u_cell (
      .clk        (clk),
      .mode       (mode),
      .left_word  (left_word),
      .right_word (right_word),
      .new_word   (new_word),
      .swap_word  (swap_word),
      .word       (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      status      <= status_next;
      entry_count <= pss_pkg::COUNT_WIDTH'(count_next);
    end
  end

endmodule

// File: sim/positional_sequence_store_test.sv
module positional_sequence_store_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH          = pss_pkg::DEFAULT_DEPTH;
  localparam int RANDOM_ITEMS   = 600;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int PLAN_LEN       = 25;

  typedef struct packed {
    pss_pkg::status_t                status;
    logic [pss_pkg::COUNT_WIDTH-1:0] count;
  } outcome_t;

  typedef struct packed {
    pss_pkg::op_t                    op;
    logic [pss_pkg::POS_WIDTH-1:0]   pos;
    logic [pss_pkg::POS_WIDTH-1:0]   other;
    logic [pss_pkg::VALUE_WIDTH-1:0] word;
    logic [4:0]                      reps;
    logic                            typed;
    pss_pkg::status_t                exp_status;
    logic [pss_pkg::COUNT_WIDTH-1:0] exp_count;
  } plan_row_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   in_valid = 1'b0;
  logic                                   in_ready;
  logic [1:0]                             operation = pss_pkg::OP_INSERT;
  logic [pss_pkg::POS_WIDTH-1:0]          position = '0;
  logic [pss_pkg::POS_WIDTH-1:0]          other_position = '0;
  logic signed [pss_pkg::VALUE_WIDTH-1:0] value = '0;
  logic                                   out_valid;
  logic                                   out_ready = 1'b0;
  logic [1:0]                             status;
  logic [pss_pkg::COUNT_WIDTH-1:0]        entry_count;

  bit steady = 1'b0;
  int mismatches = 0;
  int stalled_cycles = 0;

  logic [pss_pkg::VALUE_WIDTH-1:0] shadow_words [DEPTH];
  int                              shadow_count = 0;
  outcome_t                        pending_outcomes [$];

  // Directed: empty-store rejects, extremes, each kind of bad swap pair, fill, full store.
  plan_row_t plan [PLAN_LEN] = '{
    '{pss_pkg::OP_DELETE, 5'd1,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd0},
    '{pss_pkg::OP_SWAP,   5'd1,  5'd2,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd0},
    '{pss_pkg::OP_INSERT, 5'd1,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd0},
    '{pss_pkg::OP_INSERT, 5'd0,  5'd0,  32'h80000000, 5'd1,  1'b1, pss_pkg::ST_DONE,  5'd1},
    '{pss_pkg::OP_APPEND, 5'd0,  5'd31, 32'h7fffffff, 5'd1,  1'b1, pss_pkg::ST_DONE,  5'd2},
    '{pss_pkg::OP_INSERT, 5'd2,  5'd0,  32'hffffffff, 5'd1,  1'b1, pss_pkg::ST_DONE,  5'd3},
    '{pss_pkg::OP_INSERT, 5'd1,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd4},
    '{pss_pkg::OP_SWAP,   5'd0,  5'd2,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_SWAP,   5'd2,  5'd2,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_SWAP,   5'd3,  5'd2,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_SWAP,   5'd1,  5'd5,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_SWAP,   5'd1,  5'd4,  32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd4},
    '{pss_pkg::OP_DELETE, 5'd0,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_DELETE, 5'd5,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd4},
    '{pss_pkg::OP_DELETE, 5'd4,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd3},
    '{pss_pkg::OP_DELETE, 5'd1,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd2},
    '{pss_pkg::OP_APPEND, 5'd0,  5'd0,  32'h12345678, 5'd14, 1'b0, pss_pkg::ST_DONE,  5'd0},
    '{pss_pkg::OP_INSERT, 5'd17, 5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd16},
    '{pss_pkg::OP_INSERT, 5'd0,  5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_FULL,  5'd16},
    '{pss_pkg::OP_APPEND, 5'd31, 5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_FULL,  5'd16},
    '{pss_pkg::OP_SWAP,   5'd1,  5'd16, 32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd16},
    '{pss_pkg::OP_INSERT, 5'd31, 5'd31, 32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd16},
    '{pss_pkg::OP_DELETE, 5'd16, 5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_DONE,  5'd15},
    '{pss_pkg::OP_INSERT, 5'd15, 5'd0,  32'h55555555, 5'd1,  1'b1, pss_pkg::ST_DONE,  5'd16},
    '{pss_pkg::OP_DELETE, 5'd31, 5'd0,  32'h0,        5'd1,  1'b1, pss_pkg::ST_RANGE, 5'd16}
  };

  positional_sequence_store u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .position       (position),
    .other_position (other_position),
    .value          (value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .entry_count    (entry_count)
  );

  always #2 clk = ~clk;

  function automatic outcome_t apply_op(pss_pkg::op_t op,
                                        logic [pss_pkg::POS_WIDTH-1:0] pos,
                                        logic [pss_pkg::POS_WIDTH-1:0] other,
                                        logic [pss_pkg::VALUE_WIDTH-1:0] word);
    outcome_t res;
    int at;
    int a;
    int b;
    logic [pss_pkg::VALUE_WIDTH-1:0] tmp;
    res.status = pss_pkg::ST_DONE;
    a = int'(pos);
    b = int'(other);
    case (op)
      pss_pkg::OP_INSERT, pss_pkg::OP_APPEND: begin
        at = (op == pss_pkg::OP_APPEND) ? shadow_count : a;
        if (at > shadow_count) begin
          res.status = pss_pkg::ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          res.status = pss_pkg::ST_FULL;
        end else begin
          for (int i = shadow_count; i > at; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[at] = word;
          shadow_count++;
        end
      end
      pss_pkg::OP_DELETE: begin
        if (a == 0 || a > shadow_count) begin
          res.status = pss_pkg::ST_RANGE;
        end else begin
          for (int i = a - 1; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      default: begin
        if (a == 0 || b <= a || b > shadow_count) begin
          res.status = pss_pkg::ST_RANGE;
        end else begin
          tmp = shadow_words[a-1];
          shadow_words[a-1] = shadow_words[b-1];
          shadow_words[b-1] = tmp;
        end
      end
    endcase
    res.count = pss_pkg::COUNT_WIDTH'(shadow_count);
    return res;
  endfunction

  task automatic send_op(pss_pkg::op_t op, logic [pss_pkg::POS_WIDTH-1:0] pos,
                         logic [pss_pkg::POS_WIDTH-1:0] other,
                         logic [pss_pkg::VALUE_WIDTH-1:0] word, bit typed,
                         pss_pkg::status_t exp_status,
                         logic [pss_pkg::COUNT_WIDTH-1:0] exp_count);
    outcome_t res;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    operation      <= op;
    position       <= pos;
    other_position <= other;
    value          <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = apply_op(op, pos, other, word);
    if (typed) begin
      res.status = exp_status;
      res.count  = exp_count;
    end
    pending_outcomes.push_back(res);
  endtask

  // hold off new transactions until every result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    outcome_t exp;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result: status %0d entry_count %0d", status, entry_count);
        mismatches++;
      end else begin
        exp = pending_outcomes.pop_front();
        if (status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, status);
          mismatches++;
        end
        if (entry_count !== exp.count) begin
          $error("entry_count: expected %0d, got %0d", exp.count, entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[positional_sequence_store] ERROR");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int cnt;
    int a;
    int r;
    bit growing;
    pss_pkg::op_t op;
    logic [pss_pkg::POS_WIDTH-1:0] pos;
    logic [pss_pkg::POS_WIDTH-1:0] other;
    logic [pss_pkg::VALUE_WIDTH-1:0] word;

    growing = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      for (int j = 0; j < int'(plan[k].reps); j++) begin
        send_op(plan[k].op, plan[k].pos, plan[k].other,
                plan[k].word ^ pss_pkg::VALUE_WIDTH'(j),
                plan[k].typed, plan[k].exp_status, plan[k].exp_count);
      end
    end
    drain_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 200 && n < 350);
      if (n == 400) drain_results();
      cnt = shadow_count;
      if (cnt == DEPTH) growing = 1'b0;
      else if (cnt == 0) growing = 1'b1;
      r     = $urandom_range(99);
      word  = $urandom;
      other = pss_pkg::POS_WIDTH'($urandom);
      if ($urandom_range(9) == 0) begin
        case ($urandom_range(3))
          0:       word = 32'h80000000;
          1:       word = 32'h7fffffff;
          2:       word = 32'h0;
          default: word = 32'hffffffff;
        endcase
      end
      if (r < 10) begin
        op  = pss_pkg::op_t'(2'($urandom_range(3)));
        pos = pss_pkg::POS_WIDTH'($urandom);
      end else if (r < 28) begin
        op = pss_pkg::OP_SWAP;
        if (cnt >= 2) begin
          a     = $urandom_range(cnt - 1, 1);
          pos   = pss_pkg::POS_WIDTH'(a);
          other = pss_pkg::POS_WIDTH'($urandom_range(cnt, a + 1));
        end else begin
          pos   = 5'd1;
          other = 5'd2;
        end
      end else if (r < (growing ? 72 : 42)) begin
        op  = $urandom_range(1) ? pss_pkg::OP_APPEND : pss_pkg::OP_INSERT;
        pos = pss_pkg::POS_WIDTH'($urandom_range(cnt, 0));
      end else begin
        op  = pss_pkg::OP_DELETE;
        pos = (cnt > 0) ? pss_pkg::POS_WIDTH'($urandom_range(cnt, 1)) : 5'd1;
      end
      send_op(op, pos, other, word, 1'b0, pss_pkg::ST_DONE, '0);
    end
    steady = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[positional_sequence_store] OK");
    end else begin
      $display("[positional_sequence_store] ERROR");
    end
    $finish;
  end

endmodule

// File: positional_sequence_store.f
design/pss_pkg.sv
design/pss_cell.sv
design/positional_sequence_store.sv
sim/positional_sequence_store_test.sv
